FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tsc_pkg.sv
// Types, constants and helper functions of the tilt smoother.
package tsc_pkg;

  localparam int AXIS_W   = 12;
  localparam int TENTHS_W = 6;
  localparam int SUM_W    = 12;  // holds +/-20 * 64
  localparam int LIM_W    = 13;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int THR_W    = 5;
  localparam int LEVEL_W  = 8;
  localparam int MAG_CAP  = 11;  // any average at or above this saturates
  localparam int MAG_W    = 4;

  // Register indexes on the config port
  localparam logic REG_DEBOUNCE  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 16'd20;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 5'd13;

  // Average magnitude (capped) to color level, m*255/10 saturated
  localparam logic [LEVEL_W-1:0] LEVEL_LUT [0:MAG_CAP] = '{
    8'd0, 8'd25, 8'd51, 8'd76, 8'd102, 8'd127,
    8'd153, 8'd178, 8'd204, 8'd229, 8'd255, 8'd255
  };

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic [THR_W-1:0] alarm_threshold;
  } cfg_t;

  // Running sums after one item, plus its timestamp
  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic [TIME_W-1:0]       now;
  } sums_t;

  // count*10/1024, truncated toward zero
  function automatic logic signed [TENTHS_W-1:0] to_tenths(logic signed [AXIS_W-1:0] a);
    logic signed [15:0] p;
    logic signed [15:0] q;
    p = 16'(a) * 16'sd10;
    q = p + (p[15] ? 16'sd1023 : 16'sd0);
    return TENTHS_W'(q >>> 10);
  endfunction

endpackage

FILE: rtl/tilt_smoother_color_and_debounced_toggle.sv
// An accepted item passes the read stage, the running sums and the output register.
// Throughput: one item per cycle unless stalled; one ring read and write each.
// Ring, sums and debounce state clear at synchronous reset; ring entries not
// yet written since reset read as zero through a fill flag, so no clearing pass.
// Config registers reset to debounce_ms = 20 and alarm_threshold = 13.
module tilt_smoother_color_and_debounced_toggle #(
  parameter int WINDOW = 50
) (
  input  logic                               clk,
  input  logic                               rst,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tsc_pkg::AXIS_W-1:0]  axis_x,
  input  logic signed [tsc_pkg::AXIS_W-1:0]  axis_y,
  input  logic signed [tsc_pkg::AXIS_W-1:0]  axis_z,
  input  logic [tsc_pkg::TIME_W-1:0]         now_ms,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tsc_pkg::LEVEL_W-1:0]        red_level,
  output logic [tsc_pkg::LEVEL_W-1:0]        green_level,
  output logic [tsc_pkg::LEVEL_W-1:0]        blue_level,
  output logic                               alarm_raw,
  output logic                               led_enabled
);

  `include "assert_macros.svh"

  tsc_pkg::cfg_t   cfg;
  tsc_pkg::sums_t  sums;
  logic            sums_valid;
  logic            sums_take;
  logic            in_ready;
  logic            reg_sel;
  logic            cfg_write;

  // Config registers
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= tsc_pkg::DEBOUNCE_RST;
      cfg.alarm_threshold <= tsc_pkg::THRESHOLD_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        tsc_pkg::REG_DEBOUNCE:  cfg.debounce_ms     <= pwdata[tsc_pkg::DEB_W-1:0];
        tsc_pkg::REG_THRESHOLD: cfg.alarm_threshold <= pwdata[tsc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tsc_pkg::REG_DEBOUNCE:  prdata = 32'(cfg.debounce_ms);
      tsc_pkg::REG_THRESHOLD: prdata = 32'(cfg.alarm_threshold);
      default:                prdata = '0;
    endcase
  end

  assign in_stall = !in_ready;

  // Ring and running sums
  tsc_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z),
    .now_ms     (now_ms),
    .sums_valid (sums_valid),
    .sums_take  (sums_take),
    .sums       (sums)
  );

  // Alarm, debounce and colors
  tsc_alarm #(
    .WINDOW (WINDOW)
  ) u_alarm (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .sums_valid  (sums_valid),
    .sums_take   (sums_take),
    .sums        (sums),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .alarm_raw   (alarm_raw),
    .led_enabled (led_enabled)
  );

  // An empty output register means the whole pipe can move
  `ASSERT_IMPLY(a_no_stall_when_empty, clk, rst, !out_valid, !in_stall, "input stalled with empty output")
  // Threshold zero raises the alarm on every item
  `ASSERT_IMPLY(a_zero_threshold_alarm, clk, rst, out_valid && (cfg.alarm_threshold == '0), alarm_raw, "zero threshold without alarm")
  // The LED flag only toggles on an item whose alarm is high
  `ASSERT_IMPLY(a_toggle_on_alarm, clk, rst, led_enabled != $past(led_enabled), alarm_raw, "LED toggled without alarm")

endmodule

FILE: rtl/tsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tsc_window.sv
// Ring buffer front end: scales samples, reads the oldest entry and keeps running sums.
module tsc_window #(
  parameter int WINDOW = 50
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tsc_pkg::AXIS_W-1:0]   axis_x,
  input  logic signed [tsc_pkg::AXIS_W-1:0]   axis_y,
  input  logic signed [tsc_pkg::AXIS_W-1:0]   axis_z,
  input  logic [tsc_pkg::TIME_W-1:0]          now_ms,
  output logic                                sums_valid,
  input  logic                                sums_take,
  output tsc_pkg::sums_t                      sums
);

  localparam int POS_W = $clog2(WINDOW);
  localparam int TW    = tsc_pkg::TENTHS_W;
  localparam int SW    = tsc_pkg::SUM_W;

  logic [POS_W-1:0]            pos;
  logic                        wrapped;     // ring has been filled once
  logic                        accept;
  logic                        s1_adv;
  logic                        s2_ready;

  logic                        s1_valid;
  logic [POS_W-1:0]            s1_pos;
  logic                        s1_fresh;    // entry never written: old value is zero
  logic signed [TW-1:0]        s1_tx, s1_ty, s1_tz;
  logic [tsc_pkg::TIME_W-1:0]  s1_now;

  logic [3*TW-1:0]             old_word;
  logic signed [TW-1:0]        old_x, old_y, old_z;

  // Handshake through the two stages
  assign s2_ready = !sums_valid || sums_take;
  assign in_ready = !s1_valid || s2_ready;
  assign accept   = in_valid && in_ready;
  assign s1_adv   = s1_valid && s2_ready;

  // Ring storage, all three axes side by side
  tsc_ram #(
    .WIDTH (3*TW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos),
    .wdata ({s1_tz, s1_ty, s1_tx}),
    .re    (accept),
    .raddr (pos),
    .rdata (old_word)
  );

  // Entry being dropped from the window
  assign old_x = s1_fresh ? '0 : old_word[TW-1:0];
  assign old_y = s1_fresh ? '0 : old_word[2*TW-1:TW];
  assign old_z = s1_fresh ? '0 : old_word[3*TW-1:2*TW];

  // Write pointer and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      wrapped  <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (pos == POS_W'(WINDOW - 1)) begin
          pos     <= '0;
          wrapped <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1_pos   <= pos;
      s1_fresh <= !wrapped;
      s1_tx    <= tsc_pkg::to_tenths(axis_x);
      s1_ty    <= tsc_pkg::to_tenths(axis_y);
      s1_tz    <= tsc_pkg::to_tenths(axis_z);
      s1_now   <= now_ms;
    end
  end

  // Running sums; they double as the stage-two payload
  always_ff @(posedge clk) begin
    if (rst) begin
      sums_valid <= 1'b0;
      sums.sx    <= '0;
      sums.sy    <= '0;
      sums.sz    <= '0;
    end else begin
      if (s1_adv) begin
        sums_valid <= 1'b1;
        sums.sx    <= sums.sx + SW'(s1_tx) - SW'(old_x);
        sums.sy    <= sums.sy + SW'(s1_ty) - SW'(old_y);
        sums.sz    <= sums.sz + SW'(s1_tz) - SW'(old_z);
      end else if (sums_take) begin
        sums_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      sums.now <= s1_now;
    end
  end

endmodule

FILE: rtl/tsc_alarm.sv
// Output stage: color levels, threshold alarm, debounce and LED toggle.
module tsc_alarm #(
  parameter int WINDOW = 50
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tsc_pkg::cfg_t                      cfg,
  input  logic                               sums_valid,
  output logic                               sums_take,
  input  tsc_pkg::sums_t                     sums,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tsc_pkg::LEVEL_W-1:0]        red_level,
  output logic [tsc_pkg::LEVEL_W-1:0]        green_level,
  output logic [tsc_pkg::LEVEL_W-1:0]        blue_level,
  output logic                               alarm_raw,
  output logic                               led_enabled
);

  localparam int SW = tsc_pkg::SUM_W;
  localparam int LW = tsc_pkg::LIM_W;
  localparam int TW = tsc_pkg::TIME_W;

  logic                    prev_alarm;
  logic                    accepted_alarm;
  logic                    led_flag;
  logic [TW-1:0]           last_change;

  logic signed [LW-1:0]    lim;
  logic                    alarm;
  logic [TW-1:0]           change_next;
  logic [TW-1:0]           elapsed;
  logic                    settled;

  // Capped whole-number average magnitude of sum/WINDOW
  function automatic logic [tsc_pkg::MAG_W-1:0] avg_mag(logic signed [SW-1:0] s);
    logic [SW-1:0]               a;
    logic [tsc_pkg::MAG_W-1:0]   m;
    a = s[SW-1] ? SW'(-s) : SW'(s);
    m = '0;
    for (int k = 1; k <= tsc_pkg::MAG_CAP; k++) begin
      if (a >= SW'(k * WINDOW)) begin
        m = tsc_pkg::MAG_W'(k);
      end
    end
    return m;
  endfunction

  function automatic logic over_limit(logic signed [SW-1:0] s, logic signed [LW-1:0] l);
    return (LW'(s) >= l) || (LW'(s) <= -l);
  endfunction

  assign sums_take = sums_valid && (!out_valid || !out_stall);

  // Alarm against threshold * WINDOW
  assign lim   = $signed({2'b00, 11'(cfg.alarm_threshold * WINDOW)});
  assign alarm = over_limit(sums.sx, lim) || over_limit(sums.sy, lim) ||
                 over_limit(sums.sz, lim);

  // Debounce: a change restarts the timer, so the test fails in that item
  assign change_next = (alarm != prev_alarm) ? sums.now : last_change;
  assign elapsed     = sums.now - change_next;
  assign settled     = elapsed > TW'(cfg.debounce_ms);

  assign led_enabled = led_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      prev_alarm     <= 1'b0;
      accepted_alarm <= 1'b0;
      led_flag       <= 1'b0;
      last_change    <= '0;
    end else begin
      if (sums_take) begin
        out_valid   <= 1'b1;
        prev_alarm  <= alarm;
        last_change <= change_next;
        if (settled && (alarm != accepted_alarm)) begin
          accepted_alarm <= alarm;
          if (alarm) begin
            led_flag <= !led_flag;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // Colors show only if the LED was on before this item
    if (sums_take) begin
      alarm_raw   <= alarm;
      red_level   <= led_flag ? tsc_pkg::LEVEL_LUT[avg_mag(sums.sx)] : '0;
      green_level <= led_flag ? tsc_pkg::LEVEL_LUT[avg_mag(sums.sy)] : '0;
      blue_level  <= led_flag ? tsc_pkg::LEVEL_LUT[avg_mag(sums.sz)] : '0;
    end
  end

endmodule

FILE: test/tb_tilt_smoother_color_and_debounced_toggle.sv
// Testbench for the tilt smoother: directed table, then tilt sequences checked by a predictor.
module tb_tilt_smoother_color_and_debounced_toggle;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LEN = 50;

  typedef struct packed {
    logic [tsc_pkg::LEVEL_W-1:0] red;
    logic [tsc_pkg::LEVEL_W-1:0] green;
    logic [tsc_pkg::LEVEL_W-1:0] blue;
    logic                        alarm;
    logic                        led;
  } led_result_t;

  typedef struct packed {
    logic [tsc_pkg::AXIS_W-1:0] x;
    logic [tsc_pkg::AXIS_W-1:0] y;
    logic [tsc_pkg::AXIS_W-1:0] z;
    logic [tsc_pkg::TIME_W-1:0] t;
    logic                       typed;
    led_result_t                res;
  } tilt_row_t;

  // Rows before DIR_SPLIT run at reset settings, the rest at zero debounce and threshold
  localparam int DIR_N     = 14;
  localparam int DIR_SPLIT = 6;
  localparam tilt_row_t TILT_ROWS [DIR_N] = '{
    '{12'd0,     12'd0,     12'd0,     32'd0,          1'b1, '0},
    '{12'd2047,  -12'd2048, 12'd0,     32'd5,          1'b1, '0},
    '{-12'd2048, 12'd2047,  -12'd1,    32'd10,         1'b1, '0},
    '{-12'd103,  12'd102,   12'd103,   32'hFFFF_FFFF,  1'b1, '0},
    '{-12'd1024, 12'd1024,  12'd1023,  32'd0,          1'b1, '0},
    '{12'h555,   12'hAAA,   12'd0,     32'd1234,       1'b1, '0},
    // zero threshold: alarm on every item, first rise not yet debounced
    '{12'd0,     12'd0,     12'd0,     32'd100,        1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}},
    '{12'd2047,  12'd2047,  12'd2047,  32'd100,        1'b0, '0},
    '{12'd2047,  12'd2047,  12'd2047,  32'd101,        1'b0, '0},
    '{-12'd2048, -12'd2048, -12'd2048, 32'd102,        1'b0, '0},
    '{12'd1023,  -12'd1024, 12'h7FF,   32'hFFFF_FFFE,  1'b0, '0},
    '{-12'd2048, 12'd0,     12'd2047,  32'hFFFF_FFFF,  1'b0, '0},
    '{12'd0,     12'd0,     12'd0,     32'd0,          1'b0, '0},
    '{12'd2047,  -12'd2048, -12'd2048, 32'd1,          1'b0, '0}
  };

  // Random phases: debounce, threshold, item count, start just before the time wrap
  localparam int PH_N = 6;
  localparam int PH_DEB   [PH_N] = '{5, 0, 65535, 30, 12, 20};
  localparam int PH_THR   [PH_N] = '{3, 20, 8, 10, 0, 13};
  localparam int PH_ITEMS [PH_N] = '{250, 150, 150, 300, 100, 300};
  localparam bit PH_WRAP  [PH_N] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  logic                               clk;
  logic                               rst;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [2:0]                         paddr;
  logic [31:0]                        pwdata;
  logic [31:0]                        prdata;
  logic                               pready;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [tsc_pkg::AXIS_W-1:0]  axis_x;
  logic signed [tsc_pkg::AXIS_W-1:0]  axis_y;
  logic signed [tsc_pkg::AXIS_W-1:0]  axis_z;
  logic [tsc_pkg::TIME_W-1:0]         now_ms;
  logic                               out_valid;
  logic                               out_stall;
  logic [tsc_pkg::LEVEL_W-1:0]        red_level;
  logic [tsc_pkg::LEVEL_W-1:0]        green_level;
  logic [tsc_pkg::LEVEL_W-1:0]        blue_level;
  logic                               alarm_raw;
  logic                               led_enabled;

  // Predictor state: tenths-of-g history per axis, running sums, debounce
  int                         hist [3][WINDOW_LEN];
  int                         sums [3];
  int                         slot;
  bit                         alarm_prev;
  bit                         alarm_held;
  bit                         led_on;
  logic [tsc_pkg::TIME_W-1:0] change_ms;
  logic [tsc_pkg::DEB_W-1:0]  hold_ms;
  logic [tsc_pkg::THR_W-1:0]  trip_tenths;

  led_result_t expected_leds [$];
  int          n_mismatch = 0;
  bit          hold_req = 1'b0;

  tilt_smoother_color_and_debounced_toggle #(
    .WINDOW(WINDOW_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .axis_x(axis_x),
    .axis_y(axis_y),
    .axis_z(axis_z),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level),
    .alarm_raw(alarm_raw),
    .led_enabled(led_enabled)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // |average| in tenths of g to a color level, saturated
  function automatic logic [tsc_pkg::LEVEL_W-1:0] level_of(int sum);
    int avg;
    int lvl;
    avg = sum / WINDOW_LEN;
    if (avg < 0) avg = -avg;
    lvl = avg * 255 / 10;
    return (lvl > 255) ? 8'd255 : lvl[tsc_pkg::LEVEL_W-1:0];
  endfunction

  // One sample through the moving average, alarm and debounced toggle
  function automatic led_result_t predict_tilt_leds(
      logic signed [tsc_pkg::AXIS_W-1:0] ax,
      logic signed [tsc_pkg::AXIS_W-1:0] ay,
      logic signed [tsc_pkg::AXIS_W-1:0] az,
      logic [tsc_pkg::TIME_W-1:0] t_ms);
    int          tenths [3];
    int          lim;
    bit          trip;
    bit          shown;
    led_result_t res;
    tenths[0] = (int'(ax) * 10) / 1024;
    tenths[1] = (int'(ay) * 10) / 1024;
    tenths[2] = (int'(az) * 10) / 1024;
    lim = int'(trip_tenths) * WINDOW_LEN;
    trip = 1'b0;
    shown = led_on;
    for (int a = 0; a < 3; a++) begin
      sums[a] += tenths[a] - hist[a][slot];
      hist[a][slot] = tenths[a];
      if (sums[a] >= lim || sums[a] <= -lim) trip = 1'b1;
    end
    slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
    res.red   = shown ? level_of(sums[0]) : 8'd0;
    res.green = shown ? level_of(sums[1]) : 8'd0;
    res.blue  = shown ? level_of(sums[2]) : 8'd0;
    // debounce: elapsed time modulo 2^32 must exceed the hold time
    if (trip != alarm_prev) change_ms = t_ms;
    if (32'(t_ms - change_ms) > 32'(hold_ms) && trip != alarm_held) begin
      alarm_held = trip;
      if (trip) led_on = !led_on;
    end
    alarm_prev = trip;
    res.alarm = trip;
    res.led = led_on;
    return res;
  endfunction

  // Sample near a tilt center, clamped to the count range
  function automatic logic signed [tsc_pkg::AXIS_W-1:0] tilt_sample(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread, 0)) - spread;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[tsc_pkg::AXIS_W-1:0];
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Offer one item, hold it until taken, then record its expected result
  task automatic offer_sample(input logic signed [tsc_pkg::AXIS_W-1:0] ax,
                              input logic signed [tsc_pkg::AXIS_W-1:0] ay,
                              input logic signed [tsc_pkg::AXIS_W-1:0] az,
                              input logic [tsc_pkg::TIME_W-1:0] t_ms,
                              input bit typed, input led_result_t typed_res);
    led_result_t want;
    @(negedge clk);
    in_valid <= 1'b1;
    axis_x <= ax;
    axis_y <= ay;
    axis_z <= az;
    now_ms <= t_ms;
    do @(posedge clk); while (in_stall);
    want = predict_tilt_leds(ax, ay, az, t_ms);
    expected_leds.push_back(typed ? typed_res : want);
  endtask

  // Setup cycle then access cycle
  task automatic apb_access(input bit wr, input logic reg_idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain the pipeline, then write and read back both registers
  task automatic set_tilt_regs(input int deb, input int thr);
    logic [31:0] rd;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_access(1'b1, tsc_pkg::REG_DEBOUNCE, 32'(deb), rd);
    hold_ms = deb[tsc_pkg::DEB_W-1:0];
    apb_access(1'b0, tsc_pkg::REG_DEBOUNCE, 32'd0, rd);
    if (rd !== 32'(hold_ms)) begin
      $error("debounce_ms: expected %0d, got %0d", hold_ms, rd);
      n_mismatch++;
    end
    apb_access(1'b1, tsc_pkg::REG_THRESHOLD, 32'(thr), rd);
    trip_tenths = thr[tsc_pkg::THR_W-1:0];
    apb_access(1'b0, tsc_pkg::REG_THRESHOLD, 32'd0, rd);
    if (rd !== 32'(trip_tenths)) begin
      $error("alarm_threshold: expected %0d, got %0d", trip_tenths, rd);
      n_mismatch++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    led_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_leds.size() == 0) begin
        $error("result with no item pending");
        n_mismatch++;
      end else begin
        want = expected_leds.pop_front();
        check_field("red_level", want.red, red_level);
        check_field("green_level", want.green, green_level);
        check_field("blue_level", want.blue, blue_level);
        check_field("alarm_raw", 8'(want.alarm), 8'(alarm_raw));
        check_field("led_enabled", 8'(want.led), 8'(led_enabled));
      end
    end
  end

  // Receiver stall pattern, with one long hold on request
  initial begin : receiver_pattern
    int mode;
    int left;
    int hold_left;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 200);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= (left % 3 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tilt_smoother_color_and_debounced_toggle: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    int                                burst_left;
    int                                seg_left;
    int                                pick;
    int                                center [3];
    int                                spread [3];
    logic signed [tsc_pkg::AXIS_W-1:0] s [3];
    logic [tsc_pkg::TIME_W-1:0]        clock_ms;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    axis_x = '0;
    axis_y = '0;
    axis_z = '0;
    now_ms = '0;
    foreach (hist[a, i]) hist[a][i] = 0;
    foreach (sums[a]) sums[a] = 0;
    slot = 0;
    alarm_prev = 1'b0;
    alarm_held = 1'b0;
    led_on = 1'b0;
    change_ms = '0;
    hold_ms = tsc_pkg::DEBOUNCE_RST;
    trip_tenths = tsc_pkg::THRESHOLD_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int r = 0; r < DIR_N; r++) begin
      if (r == DIR_SPLIT) begin
        idle_cycle();
        set_tilt_regs(0, 0);
      end
      offer_sample(TILT_ROWS[r].x, TILT_ROWS[r].y, TILT_ROWS[r].z, TILT_ROWS[r].t,
                   TILT_ROWS[r].typed, TILT_ROWS[r].res);
    end

    // Random tilt sequences across several register settings
    burst_left = 0;
    seg_left = 0;
    clock_ms = 32'd2000;
    for (int ph = 0; ph < PH_N; ph++) begin
      idle_cycle();
      set_tilt_regs(PH_DEB[ph], PH_THR[ph]);
      if (PH_WRAP[ph]) clock_ms = 32'hFFFF_FC00;
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PH_ITEMS[ph]; n++) begin
        // a new steady tilt every so often
        if (seg_left == 0) begin
          for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 5))
              0: center[a] = -2048;
              1: center[a] = 2047;
              2: center[a] = 0;
              default: center[a] = int'($urandom_range(0, 4095)) - 2048;
            endcase
            case ($urandom_range(0, 3))
              0: spread[a] = 0;
              1: spread[a] = 16;
              2: spread[a] = 128;
              default: spread[a] = 600;
            endcase
          end
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        for (int a = 0; a < 3; a++) begin
          if ($urandom_range(0, 9) == 0) s[a] = tsc_pkg::AXIS_W'($urandom);
          else s[a] = tilt_sample(center[a], spread[a]);
        end
        // mostly small time steps, some repeats, jumps and arbitrary values
        pick = $urandom_range(0, 99);
        if (pick < 2) clock_ms = $urandom;
        else if (pick < 5) clock_ms += $urandom_range(0, 100000);
        else if (pick >= 8) clock_ms += $urandom_range(1, 12);
        if (burst_left == 0) begin
          repeat ($urandom_range(0, 6)) idle_cycle();
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        offer_sample(s[0], s[1], s[2], clock_ms, 1'b0, '0);
      end
    end
    idle_cycle();

    while (expected_leds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("tilt_smoother_color_and_debounced_toggle: match");
    end else begin
      $display("tilt_smoother_color_and_debounced_toggle: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_ram.sv
rtl/tsc_window.sv
rtl/tsc_alarm.sv
rtl/tilt_smoother_color_and_debounced_toggle.sv
test/tb_tilt_smoother_color_and_debounced_toggle.sv
